>>> design/nusc_pkg.sv
// shared types, constants and start code compare for the annex b start code splitter
// no dependencies
`timescale 1ns / 1ps

package nusc_pkg;

    localparam int WIN_DEPTH = 4;
    localparam int MAX_RESULTS = 4;

    localparam logic [2:0] SC_LEN_NONE = 3'd0;
    localparam logic [2:0] SC_LEN_3 = 3'd3;
    localparam logic [2:0] SC_LEN_4 = 3'd4;

    typedef struct packed {
        logic [7:0] data;
        logic       first;
        logic [2:0] sc_len;
        logic       last;
        logic       orphan;
    } rec_t;

    // all results caused by one request
    typedef struct packed {
        rec_t [MAX_RESULTS-1:0] recs;
        logic [2:0]             cnt;
    } batch_t;

    // start code length at b0 with m bytes known from there
    function automatic logic [2:0] sc_len(
        input logic [7:0] b0,
        input logic [7:0] b1,
        input logic [7:0] b2,
        input logic [7:0] b3,
        input logic [2:0] m,
        input logic       blocked
    );
        logic [2:0] res;
        res = SC_LEN_NONE;
        if (!blocked)
        begin
            if (m >= 3'd4 && b0 == 8'h00 && b1 == 8'h00 && b2 == 8'h00 && b3 == 8'h01)
            begin
                res = SC_LEN_4;
            end
            else if (m >= 3'd3 && b0 == 8'h00 && b1 == 8'h00 && b2 == 8'h01)
            begin
                res = SC_LEN_3;
            end
        end
        return res;
    endfunction

endpackage

>>> design/nusc_front.sv
// front end: look-ahead window, start code detection, builds at most one batch per request
// depends on nusc_pkg
`timescale 1ns / 1ps

module nusc_front
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  byte_valid,
    output logic                  byte_stall,
    input  logic [7:0]            data_byte,
    input  logic                  end_of_stream,
    output logic                  push,
    output nusc_pkg::batch_t      push_batch,
    input  logic                  queue_full
);

    logic [7:0] lb_reg [nusc_pkg::WIN_DEPTH];
    logic [7:0] lb_next [nusc_pkg::WIN_DEPTH];
    logic [2:0] fill_reg, fill_next;
    logic       sup_reg, sup_next;
    logic       ins_reg, ins_next;
    logic       drain_reg, drain_next;

    logic             accept;
    logic [2:0]       fill_e;
    logic             sup_e;
    logic             ins_e;
    logic [7:0]       bytes [8];
    logic [2:0]       n;
    logic [2:0]       nh;
    logic [2:0]       m [nusc_pkg::MAX_RESULTS];
    logic             sup_after [nusc_pkg::MAX_RESULTS];
    logic             ins_after [nusc_pkg::MAX_RESULTS];
    nusc_pkg::rec_t   h [nusc_pkg::MAX_RESULTS];
    nusc_pkg::rec_t   drain_rec;
    logic             s_cur;
    logic             i_cur;
    logic [2:0]       len_c;

    assign byte_stall = queue_full;
    assign accept = byte_valid && !queue_full;

    always_comb
    begin
        fill_e = drain_reg ? 3'd0 : fill_reg;
        sup_e = drain_reg ? 1'b0 : sup_reg;
        ins_e = drain_reg ? 1'b0 : ins_reg;

        for (int i = 0; i < 8; i++)
        begin
            bytes[i] = 8'h00;
            if (i < nusc_pkg::WIN_DEPTH && 3'(i) < fill_e)
            begin
                bytes[i] = lb_reg[i];
            end
        end
        bytes[fill_e] = data_byte;
        n = fill_e + 3'd1;

        // chained head releases
        s_cur = sup_e;
        i_cur = ins_e;
        for (int i = 0; i < nusc_pkg::MAX_RESULTS; i++)
        begin
            m[i] = n - 3'(i);
            len_c = nusc_pkg::sc_len(bytes[i], bytes[i+1], bytes[i+2], bytes[i+3], m[i], s_cur);
            s_cur = (len_c != nusc_pkg::SC_LEN_NONE);
            i_cur = i_cur | s_cur;
            sup_after[i] = s_cur;
            ins_after[i] = i_cur;
            h[i].data = bytes[i];
            h[i].first = s_cur;
            h[i].sc_len = len_c;
            h[i].orphan = !i_cur;
            if (m[i] <= 3'd1)
            begin
                h[i].last = 1'b1;
            end
            else
            begin
                h[i].last = nusc_pkg::sc_len(bytes[i+1], bytes[i+2], bytes[i+3], bytes[i+4],
                                             m[i] - 3'd1, s_cur) != nusc_pkg::SC_LEN_NONE;
            end
        end

        if (end_of_stream)
        begin
            nh = (n > 3'd4) ? 3'd4 : n;
        end
        else
        begin
            nh = (fill_e == 3'd4) ? 3'd1 : 3'd0;
        end

        drain_rec.data = lb_reg[0];
        drain_rec.first = 1'b0;
        drain_rec.sc_len = nusc_pkg::SC_LEN_NONE;
        drain_rec.last = 1'b1;
        drain_rec.orphan = !ins_reg;

        for (int j = 0; j < nusc_pkg::MAX_RESULTS; j++)
        begin
            push_batch.recs[j] = h[j];
        end
        push_batch.cnt = nh;
        if (drain_reg)
        begin
            push_batch.recs[0] = drain_rec;
            push_batch.recs[1] = h[0];
            push_batch.cnt = nh + 3'd1;
        end
        push = accept && (push_batch.cnt != 3'd0);

        // next state
        for (int j = 0; j < nusc_pkg::WIN_DEPTH; j++)
        begin
            lb_next[j] = lb_reg[j];
        end
        fill_next = fill_reg;
        sup_next = sup_reg;
        ins_next = ins_reg;
        drain_next = drain_reg;
        if (accept)
        begin
            if (!end_of_stream)
            begin
                drain_next = 1'b0;
                if (fill_e == 3'd4)
                begin
                    for (int j = 0; j < nusc_pkg::WIN_DEPTH; j++)
                    begin
                        lb_next[j] = bytes[j+1];
                    end
                    fill_next = 3'd4;
                    sup_next = sup_after[0];
                    ins_next = ins_after[0];
                end
                else
                begin
                    lb_next[fill_e[1:0]] = data_byte;
                    fill_next = fill_e + 3'd1;
                    sup_next = sup_e;
                    ins_next = ins_e;
                end
            end
            else if (n > 3'd4)
            begin
                lb_next[0] = bytes[4];
                fill_next = 3'd1;
                sup_next = 1'b0;
                ins_next = ins_after[nusc_pkg::MAX_RESULTS-1];
                drain_next = 1'b1;
            end
            else
            begin
                fill_next = 3'd0;
                sup_next = 1'b0;
                ins_next = 1'b0;
                drain_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_reg <= 3'd0;
            sup_reg <= 1'b0;
            ins_reg <= 1'b0;
            drain_reg <= 1'b0;
        end
        else
        begin
            fill_reg <= fill_next;
            sup_reg <= sup_next;
            ins_reg <= ins_next;
            drain_reg <= drain_next;
        end
    end

    always_ff @(posedge clk)
    begin
        for (int j = 0; j < nusc_pkg::WIN_DEPTH; j++)
        begin
            lb_reg[j] <= lb_next[j];
        end
    end

endmodule

>>> design/nusc_queue.sv
// short batch queue between front and back ends
// depends on nusc_pkg
`timescale 1ns / 1ps

module nusc_queue
#(
    parameter int DEPTH = 2
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  nusc_pkg::batch_t push_batch,
    output logic             full,
    input  logic             pop,
    output logic             head_valid,
    output nusc_pkg::batch_t head_batch
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    nusc_pkg::batch_t mem [DEPTH];
    logic [PW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0] count_reg, count_next;
    logic          do_push;
    logic          do_pop;

    assign full = (count_reg == CW'(DEPTH));
    assign head_valid = (count_reg != '0);
    assign head_batch = mem[rd_ptr_reg];
    assign do_push = push && !full;
    assign do_pop = pop && head_valid;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (!do_push && do_pop)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem[wr_ptr_reg] <= push_batch;
        end
    end

endmodule

>>> design/nusc_back.sv
// back end: sends the results of the head batch one per cycle while unit_stall is low
// depends on nusc_pkg
`timescale 1ns / 1ps

module nusc_back
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             head_valid,
    input  nusc_pkg::batch_t head_batch,
    output logic             pop,
    output logic             unit_valid,
    input  logic             unit_stall,
    output logic [7:0]       out_byte,
    output logic             unit_first,
    output logic [2:0]       start_code_len,
    output logic             unit_last,
    output logic             orphan,
    output logic             run_last
);

    logic [1:0]     idx_reg, idx_next;
    nusc_pkg::rec_t cur;
    logic           sent;

    assign cur = head_batch.recs[idx_reg];
    assign unit_valid = head_valid;
    assign out_byte = cur.data;
    assign unit_first = cur.first;
    assign start_code_len = cur.sc_len;
    assign unit_last = cur.last;
    assign orphan = cur.orphan;
    assign run_last = ({1'b0, idx_reg} == head_batch.cnt - 3'd1);
    assign sent = head_valid && !unit_stall;
    assign pop = sent && run_last;

    always_comb
    begin
        idx_next = idx_reg;
        if (pop)
        begin
            idx_next = 2'd0;
        end
        else if (sent)
        begin
            idx_next = idx_reg + 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg <= 2'd0;
        end
        else
        begin
            idx_reg <= idx_next;
        end
    end

endmodule

>>> design/nal_unit_start_code_splitter_core.sv
// annex b start code splitter: one stream byte in, marked delayed bytes out
// a byte released by a request is registered in the batch queue and shows when its batch is at the queue head
// throughput: one byte per cycle while byte_stall is low; an end-of-stream request sends up to four results,
//   one per cycle from the back end while unit_stall is low, and the queue lets the front end keep taking bytes
// reset: window empty, no unit open, queue empty
// depends on nusc_pkg, nusc_front, nusc_queue, nusc_back
`timescale 1ns / 1ps

module nal_unit_start_code_splitter_core
#(
    parameter int QUEUE_DEPTH = 2
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       byte_valid,
    output logic       byte_stall,
    input  logic [7:0] data_byte,
    input  logic       end_of_stream,
    output logic       unit_valid,
    input  logic       unit_stall,
    output logic [7:0] out_byte,
    output logic       unit_first,
    output logic [2:0] start_code_len,
    output logic       unit_last,
    output logic       orphan,
    output logic       run_last
);

    logic             push;
    nusc_pkg::batch_t push_batch;
    logic             queue_full;
    logic             pop;
    logic             head_valid;
    nusc_pkg::batch_t head_batch;

    nusc_front u_front
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .byte_valid    (byte_valid),
        .byte_stall    (byte_stall),
        .data_byte     (data_byte),
        .end_of_stream (end_of_stream),
        .push          (push),
        .push_batch    (push_batch),
        .queue_full    (queue_full)
    );

    nusc_queue #(.DEPTH(QUEUE_DEPTH)) u_queue
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_batch (push_batch),
        .full       (queue_full),
        .pop        (pop),
        .head_valid (head_valid),
        .head_batch (head_batch)
    );

    nusc_back u_back
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .head_valid     (head_valid),
        .head_batch     (head_batch),
        .pop            (pop),
        .unit_valid     (unit_valid),
        .unit_stall     (unit_stall),
        .out_byte       (out_byte),
        .unit_first     (unit_first),
        .start_code_len (start_code_len),
        .unit_last      (unit_last),
        .orphan         (orphan),
        .run_last       (run_last)
    );

endmodule
